### hw/rtl/srsu_pkg.sv
// shared types, constants and the row compare function for the sorted row set union
`timescale 1ns / 1ps
package srsu_pkg;

  localparam int SEG_FIELDS       = 4;
  localparam int SEG_W            = 64;
  localparam int DATA_W           = SEG_FIELDS * SEG_W;
  localparam int REQ_W            = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 12;
  localparam int NSEG_W           = 3;
  localparam int DEF_MAX_SEGMENTS = 4;
  localparam int DEF_ROWS         = 1024;

  localparam logic [REQ_W-1:0] REQ_LOAD_L = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_R = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PULL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SEGMENTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_ROWS   = 2'd1;

  typedef struct packed {
    logic load;       // write loaded row into the store of side
    logic start;      // first pull: enter merge phase
    logic sort_init;  // order[0] = 0, i = 1
    logic key_rd;     // read store[i], j = i
    logic key_latch;  // key row from store read data
    logic place;      // order[j] = i, i++
    logic ord_rd;     // read order[j-1]
    logic idx_rd;     // latch order data, read the row it points at
    logic shift;      // order[j] = idx, j--
    logic mord;       // merge: read both order heads
    logic msto;       // merge: read both head rows
    logic emit;       // merge: build the result transfer
    logic side;       // 0 left, 1 right
  } dp_cmd_t;

  typedef struct packed {
    logic merge_phase;
    logic both_loaded;
    logic i_done;
    logic j_zero;
    logic key_less;
    logic out_free;
  } dp_stat_t;

  // a sorts strictly before b over the first n segments
  function automatic logic row_less(input logic [DATA_W-1:0] a,
                                    input logic [DATA_W-1:0] b,
                                    input logic [NSEG_W-1:0] n);
    logic lt;
    logic decided;
    lt      = 1'b0;
    decided = 1'b0;
    for (int s = 0; s < SEG_FIELDS; s++) begin
      if (!decided && (s < int'(n))) begin
        if (a[s*SEG_W +: SEG_W] < b[s*SEG_W +: SEG_W]) begin
          lt      = 1'b1;
          decided = 1'b1;
        end else if (b[s*SEG_W +: SEG_W] < a[s*SEG_W +: SEG_W]) begin
          decided = 1'b1;
        end
      end
    end
    return lt;
  endfunction

endpackage

### hw/rtl/srsu_ctrl.sv
// controller: request decode, insertion sort sequencer and merge sequencer
`timescale 1ns / 1ps
module srsu_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [srsu_pkg::REQ_W-1:0] req_type,
  input  srsu_pkg::dp_stat_t       stat,
  output logic                     idle,
  output srsu_pkg::dp_cmd_t        cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SINIT = 4'd1;
  localparam logic [3:0] ST_SKEY  = 4'd2;
  localparam logic [3:0] ST_SKEYL = 4'd3;
  localparam logic [3:0] ST_SJ    = 4'd4;
  localparam logic [3:0] ST_SJO   = 4'd5;
  localparam logic [3:0] ST_SJS   = 4'd6;
  localparam logic [3:0] ST_MORD  = 4'd7;
  localparam logic [3:0] ST_MSTO  = 4'd8;
  localparam logic [3:0] ST_MEMIT = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       side;
  logic       side_next;

  assign idle = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      side  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
    end
  end

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd        = '0;
    cmd.side   = side;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type) inside
            srsu_pkg::REQ_LOAD_L, srsu_pkg::REQ_LOAD_R: begin
              cmd.load = 1'b1;
              cmd.side = req_type[0];
            end
            srsu_pkg::REQ_PULL: begin
              if (stat.merge_phase) begin
                state_next = ST_MORD;
              end else begin
                cmd.start  = 1'b1;
                side_next  = 1'b0;
                state_next = stat.both_loaded ? ST_SINIT : ST_MORD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SINIT: begin
        cmd.sort_init = 1'b1;
        state_next    = ST_SKEY;
      end
      ST_SKEY: begin
        if (stat.i_done) begin
          if (!side) begin
            side_next  = 1'b1;
            state_next = ST_SINIT;
          end else begin
            state_next = ST_MORD;
          end
        end else begin
          cmd.key_rd = 1'b1;
          state_next = ST_SKEYL;
        end
      end
      ST_SKEYL: begin
        cmd.key_latch = 1'b1;
        state_next    = ST_SJ;
      end
      ST_SJ: begin
        if (stat.j_zero) begin
          cmd.place  = 1'b1;
          state_next = ST_SKEY;
        end else begin
          cmd.ord_rd = 1'b1;
          state_next = ST_SJO;
        end
      end
      ST_SJO: begin
        cmd.idx_rd = 1'b1;
        state_next = ST_SJS;
      end
      ST_SJS: begin
        if (stat.key_less) begin
          cmd.shift  = 1'b1;
          state_next = ST_SJ;
        end else begin
          cmd.place  = 1'b1;
          state_next = ST_SKEY;
        end
      end
      ST_MORD: begin
        cmd.mord   = 1'b1;
        state_next = ST_MSTO;
      end
      ST_MSTO: begin
        cmd.msto   = 1'b1;
        state_next = ST_MEMIT;
      end
      ST_MEMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/srsu_dp.sv
// datapath: row stores, order tables, cursors, comparators and the output register
`timescale 1ns / 1ps
module srsu_dp #(
  parameter int MAX_SEGMENTS = srsu_pkg::DEF_MAX_SEGMENTS,
  parameter int ROWS         = srsu_pkg::DEF_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  srsu_pkg::dp_cmd_t                 cmd,
  output srsu_pkg::dp_stat_t                stat,
  input  logic [srsu_pkg::DATA_W-1:0]       in_row,
  input  logic                              cfg_we,
  input  logic [srsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srsu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srsu_pkg::DATA_W-1:0]       out_data,
  output logic                              out_row_valid,
  output logic                              out_chunk_end,
  output logic                              out_last_row
);

  localparam int SL = (MAX_SEGMENTS < srsu_pkg::SEG_FIELDS) ? MAX_SEGMENTS
                                                            : srsu_pkg::SEG_FIELDS;
  localparam int RW = SL * srsu_pkg::SEG_W;
  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = $clog2(ROWS + 1);
  localparam int FW = (CW + 1 > srsu_pkg::CFG_DATA_W) ? CW + 1 : srsu_pkg::CFG_DATA_W;
  localparam int DW = srsu_pkg::DATA_W;

  logic [RW-1:0] lmem [ROWS];
  logic [RW-1:0] rmem [ROWS];
  logic [AW-1:0] lord [ROWS];
  logic [AW-1:0] rord [ROWS];

  logic [srsu_pkg::NSEG_W-1:0]   num_segments;
  logic [srsu_pkg::CFG_DATA_W-1:0] chunk_rows;
  logic [srsu_pkg::NSEG_W-1:0]   nseg;

  logic [CW-1:0] lcnt, rcnt, lcur, rcur, i, j;
  logic [FW-1:0] fill;
  logic          merge_phase, sorted;
  logic [RW-1:0] l_srd, r_srd, key;
  logic [AW-1:0] l_ord_q, r_ord_q, idx;

  // effective segment count, clamped to 1..SL
  always_comb begin
    nseg = num_segments;
    if (num_segments == '0) nseg = srsu_pkg::NSEG_W'(1);
    else if (int'(num_segments) > SL) nseg = srsu_pkg::NSEG_W'(SL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_segments <= srsu_pkg::NSEG_W'(1);
      chunk_rows   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == srsu_pkg::CFG_NUM_SEGMENTS)
        num_segments <= cfg_data[srsu_pkg::NSEG_W-1:0];
      else if (cfg_index == srsu_pkg::CFG_CHUNK_ROWS)
        chunk_rows <= cfg_data;
    end
  end

  // store write from loads
  logic l_we, r_we;
  assign l_we = cmd.load && !cmd.side && !merge_phase && (lcnt < CW'(ROWS));
  assign r_we = cmd.load &&  cmd.side && !merge_phase && (rcnt < CW'(ROWS));

  // store read ports
  logic          l_sre, r_sre;
  logic [AW-1:0] l_sra, r_sra;
  assign l_sre = ((cmd.key_rd || cmd.idx_rd) && !cmd.side) || cmd.msto;
  assign r_sre = ((cmd.key_rd || cmd.idx_rd) &&  cmd.side) || cmd.msto;
  assign l_sra = cmd.key_rd ? i[AW-1:0] :
                 (cmd.idx_rd || sorted) ? l_ord_q : lcur[AW-1:0];
  assign r_sra = cmd.key_rd ? i[AW-1:0] :
                 (cmd.idx_rd || sorted) ? r_ord_q : rcur[AW-1:0];

  // order read and write ports
  logic [AW-1:0] jm1;
  logic          l_ore, r_ore, l_owe, r_owe;
  logic [AW-1:0] l_ora, r_ora, owa, owd;
  assign jm1   = AW'(j - CW'(1));
  assign l_ore = (cmd.ord_rd && !cmd.side) || cmd.mord;
  assign r_ore = (cmd.ord_rd &&  cmd.side) || cmd.mord;
  assign l_ora = cmd.ord_rd ? jm1 : lcur[AW-1:0];
  assign r_ora = cmd.ord_rd ? jm1 : rcur[AW-1:0];
  assign l_owe = (cmd.sort_init || cmd.place || cmd.shift) && !cmd.side;
  assign r_owe = (cmd.sort_init || cmd.place || cmd.shift) &&  cmd.side;
  assign owa   = cmd.sort_init ? '0 : j[AW-1:0];
  assign owd   = cmd.sort_init ? '0 : (cmd.shift ? idx : i[AW-1:0]);

  always_ff @(posedge clk) begin
    if (l_we) lmem[lcnt[AW-1:0]] <= in_row[RW-1:0];
    if (r_we) rmem[rcnt[AW-1:0]] <= in_row[RW-1:0];
    if (l_sre) l_srd <= lmem[l_sra];
    if (r_sre) r_srd <= rmem[r_sra];
  end

  always_ff @(posedge clk) begin
    if (l_owe) lord[owa] <= owd;
    if (r_owe) rord[owa] <= owd;
    if (l_ore) l_ord_q <= lord[l_ora];
    if (r_ore) r_ord_q <= rord[r_ora];
  end

  // sort payload registers
  always_ff @(posedge clk) begin
    if (cmd.key_latch) key <= cmd.side ? r_srd : l_srd;
    if (cmd.idx_rd) idx <= cmd.side ? r_ord_q : l_ord_q;
  end

  logic key_less, rr_lt_lr, lr_lt_rr;
  assign key_less = srsu_pkg::row_less(DW'(key), DW'(cmd.side ? r_srd : l_srd), nseg);
  assign rr_lt_lr = srsu_pkg::row_less(DW'(r_srd), DW'(l_srd), nseg);
  assign lr_lt_rr = srsu_pkg::row_less(DW'(l_srd), DW'(r_srd), nseg);

  // merge choice
  logic          l_done, r_done, take_r, adv_l, adv_r, last;
  logic [CW-1:0] lcur_next, rcur_next;
  logic [DW-1:0] pick, masked;
  logic [FW-1:0] fill_inc;
  logic          chunk_hit;
  assign l_done    = (lcur >= lcnt);
  assign r_done    = (rcur >= rcnt);
  assign take_r    = l_done || (!r_done && rr_lt_lr);
  assign adv_l     = !l_done && !take_r;
  assign adv_r     = !r_done && (take_r || (!l_done && !lr_lt_rr));
  assign lcur_next = lcur + CW'(adv_l);
  assign rcur_next = rcur + CW'(adv_r);
  assign last      = (lcur_next >= lcnt) && (rcur_next >= rcnt);
  assign pick      = take_r ? DW'(r_srd) : DW'(l_srd);
  assign fill_inc  = fill + FW'(1);
  assign chunk_hit = (chunk_rows != '0) && (fill_inc >= FW'(chunk_rows));

  always_comb begin
    masked = '0;
    for (int s = 0; s < srsu_pkg::SEG_FIELDS; s++) begin
      if (s < int'(nseg))
        masked[s*srsu_pkg::SEG_W +: srsu_pkg::SEG_W] = pick[s*srsu_pkg::SEG_W +: srsu_pkg::SEG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcnt        <= '0;
      rcnt        <= '0;
      lcur        <= '0;
      rcur        <= '0;
      fill        <= '0;
      merge_phase <= 1'b0;
      sorted      <= 1'b0;
      i           <= '0;
      j           <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (l_we) lcnt <= lcnt + CW'(1);
      if (r_we) rcnt <= rcnt + CW'(1);
      if (cmd.start) begin
        merge_phase <= 1'b1;
        sorted      <= (lcnt != '0) && (rcnt != '0);
      end
      if (cmd.sort_init) i <= CW'(1);
      if (cmd.place) i <= i + CW'(1);
      if (cmd.key_rd) j <= i;
      if (cmd.shift) j <= j - CW'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (!(l_done && r_done)) begin
          lcur <= lcur_next;
          rcur <= rcur_next;
          fill <= chunk_hit ? '0 : fill_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (l_done && r_done) begin
        out_data      <= '0;
        out_row_valid <= 1'b0;
        out_chunk_end <= 1'b0;
        out_last_row  <= 1'b0;
      end else begin
        out_data      <= masked;
        out_row_valid <= 1'b1;
        out_chunk_end <= chunk_hit;
        out_last_row  <= last;
      end
    end
  end

  assign stat.merge_phase = merge_phase;
  assign stat.both_loaded = (lcnt != '0) && (rcnt != '0);
  assign stat.i_done      = i >= (cmd.side ? rcnt : lcnt);
  assign stat.j_zero      = (j == '0);
  assign stat.key_less    = key_less;
  assign stat.out_free    = !out_valid || out_ready;

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (lcur <= lcnt) && (rcur <= rcnt)) else $error("merge cursor past row count");
  a_merge_sticky: assert property (@(posedge clk) disable iff (rst)
    merge_phase |=> merge_phase) else $error("merge phase dropped without reset");
  a_no_load_in_merge: assert property (@(posedge clk) disable iff (rst)
    merge_phase |=> ($stable(lcnt) && $stable(rcnt))) else $error("row stored while merging");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready)) else $error("result overwrote pending transfer");

endmodule

### hw/rtl/sorted_row_set_union.sv
// top level of the sorted row set union: stream ports, config port, controller and datapath
`timescale 1ns / 1ps
// Loads (request kind 0 left, 1 right) are taken back to back: the next item is taken in the
// following cycle, even while a result transfer is still pending. A pull after the first steps
// through an order table read, a row store read, and the compare and result register, plus any
// wait on m_axis_tready. The first pull also runs an insertion sort on each side when both sides
// hold rows: for each row a key read and latch, then for each row it moves past an order table
// read, a row store read and a compare, all through the single read port of each side's row
// store. The row stores hold ROWS rows per side; loads beyond that are dropped.
module sorted_row_set_union #(
  parameter int MAX_SEGMENTS = srsu_pkg::DEF_MAX_SEGMENTS,
  parameter int ROWS         = srsu_pkg::DEF_ROWS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [srsu_pkg::DATA_W-1:0]      s_axis_tdata,  // in_seg0, in_seg1, in_seg2, in_seg3
  input  logic [srsu_pkg::REQ_W-1:0]       s_axis_tuser,  // req_type
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [srsu_pkg::DATA_W-1:0]      m_axis_tdata,  // out_seg0, out_seg1, out_seg2, out_seg3
  output logic [1:0]                       m_axis_tuser,  // row_valid, last_row
  output logic                             m_axis_tlast,  // chunk_end
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [srsu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srsu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  srsu_pkg::dp_cmd_t  cmd;
  srsu_pkg::dp_stat_t stat;
  logic               idle;
  logic               accept;
  logic               row_valid;
  logic               last_row;

  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tuser  = {last_row, row_valid};

  srsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req_type (s_axis_tuser),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  srsu_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ROWS         (ROWS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_row        (s_axis_tdata),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_data      (m_axis_tdata),
    .out_row_valid (row_valid),
    .out_chunk_end (m_axis_tlast),
    .out_last_row  (last_row)
  );

endmodule

### sim/testbench.sv
// self-checking testbench for the sorted row set union
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [srsu_pkg::DATA_W-1:0] segs;
    logic                        row_valid;
    logic                        chunk_end;
    logic                        last_row;
  } union_row_t;

  typedef struct packed {
    logic [srsu_pkg::REQ_W-1:0]  req;
    logic [srsu_pkg::DATA_W-1:0] data;
  } stim_t;

  localparam int ROWS = srsu_pkg::DEF_ROWS;
  localparam int DW   = srsu_pkg::DATA_W;
  localparam int SW   = srsu_pkg::SEG_W;
  localparam logic [SW-1:0] ONES = {SW{1'b1}};
  localparam logic [srsu_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [DW-1:0]                   s_axis_tdata = '0;
  logic [srsu_pkg::REQ_W-1:0]      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [DW-1:0]                   m_axis_tdata;
  logic [1:0]                      m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [srsu_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [srsu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  sorted_row_set_union i_dut (.*);

  // own copy of the union state
  logic [srsu_pkg::NSEG_W-1:0]     seg_cfg = 3'd1;
  logic [srsu_pkg::CFG_DATA_W-1:0] chunk_cfg = '0;
  logic [DW-1:0]         side_rows [2][ROWS];
  int                    side_ord [2][ROWS];
  int                    side_cnt [2] = '{0, 0};
  int                    side_cur [2] = '{0, 0};
  int                    chunk_fill = 0;
  bit                    merging = 1'b0;
  union_row_t            pending_rows[$];
  int                    mismatches = 0;
  bit                    quiet = 1'b0;
  int                    stall_left = 0;
  logic [srsu_pkg::CFG_DATA_W-1:0] seg_plan [6] = '{3, 1, 0, 7, 4, 2};
  logic [srsu_pkg::CFG_DATA_W-1:0] chunk_plan [6] = '{5, 1, 4095, 2048, 0, 3};

  function automatic int seg_count();
    if (seg_cfg == 0) return 1;
    if (seg_cfg > srsu_pkg::SEG_FIELDS) return srsu_pkg::SEG_FIELDS;
    return int'(seg_cfg);
  endfunction

  function automatic bit row_before(logic [DW-1:0] a, logic [DW-1:0] b);
    for (int s = 0; s < seg_count(); s++) begin
      if (a[s*SW +: SW] < b[s*SW +: SW]) return 1'b1;
      if (a[s*SW +: SW] > b[s*SW +: SW]) return 1'b0;
    end
    return 1'b0;
  endfunction

  task automatic order_side(int sd, bit sort_it);
    int key;
    int j;
    for (int i = 0; i < side_cnt[sd]; i++) side_ord[sd][i] = i;
    if (sort_it) begin
      for (int i = 1; i < side_cnt[sd]; i++) begin
        key = side_ord[sd][i];
        j = i;
        while (j > 0 && row_before(side_rows[sd][key], side_rows[sd][side_ord[sd][j-1]])) begin
          side_ord[sd][j] = side_ord[sd][j-1];
          j--;
        end
        side_ord[sd][j] = key;
      end
    end
  endtask

  task automatic union_step(logic [srsu_pkg::REQ_W-1:0] req, logic [DW-1:0] data);
    union_row_t r;
    logic [DW-1:0] pick;
    logic [DW-1:0] lrow;
    logic [DW-1:0] rrow;
    bit both;
    r = '0;
    if (req == srsu_pkg::REQ_LOAD_L || req == srsu_pkg::REQ_LOAD_R) begin
      if (!merging && side_cnt[req[0]] < ROWS) begin
        side_rows[req[0]][side_cnt[req[0]]] = data;
        side_cnt[req[0]]++;
      end
      return;
    end
    if (req != srsu_pkg::REQ_PULL) return;
    if (!merging) begin
      merging = 1'b1;
      both = side_cnt[0] != 0 && side_cnt[1] != 0;
      order_side(0, both);
      order_side(1, both);
    end
    if (side_cur[0] < side_cnt[0] || side_cur[1] < side_cnt[1]) begin
      if (side_cur[0] >= side_cnt[0]) begin
        pick = side_rows[1][side_ord[1][side_cur[1]]];
        side_cur[1]++;
      end else if (side_cur[1] >= side_cnt[1]) begin
        pick = side_rows[0][side_ord[0][side_cur[0]]];
        side_cur[0]++;
      end else begin
        lrow = side_rows[0][side_ord[0][side_cur[0]]];
        rrow = side_rows[1][side_ord[1][side_cur[1]]];
        if (row_before(rrow, lrow)) begin
          pick = rrow;
          side_cur[1]++;
        end else begin
          pick = lrow;
          // equal heads pair up across the sides
          if (!row_before(lrow, rrow)) side_cur[1]++;
          side_cur[0]++;
        end
      end
      for (int s = 0; s < seg_count(); s++) r.segs[s*SW +: SW] = pick[s*SW +: SW];
      r.row_valid = 1'b1;
      chunk_fill++;
      if (chunk_cfg != 0 && chunk_fill >= chunk_cfg) begin
        r.chunk_end = 1'b1;
        chunk_fill = 0;
      end
      r.last_row = side_cur[0] >= side_cnt[0] && side_cur[1] >= side_cnt[1];
    end
    pending_rows.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [srsu_pkg::REQ_W-1:0] req, logic [DW-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    union_step(req, data);
  endtask

  task automatic write_reg(logic [srsu_pkg::CFG_IDX_W-1:0] idx,
                           logic [srsu_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == srsu_pkg::CFG_NUM_SEGMENTS) seg_cfg = val[srsu_pkg::NSEG_W-1:0];
    else chunk_cfg = val;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] rand_seg();
    case ($urandom_range(0, 3))
      0: return SW'($urandom_range(0, 3));
      1: return {$urandom, $urandom};
      2: return ONES;
      default: return {32'($urandom_range(0, 2)), 32'($urandom_range(0, 5))};
    endcase
  endfunction

  // mostly fresh rows, some copies of earlier rows so equal rows show up
  function automatic logic [DW-1:0] rand_row();
    int sd;
    sd = $urandom_range(0, 1);
    if (side_cnt[sd] != 0 && $urandom_range(0, 3) == 0)
      return side_rows[sd][$urandom_range(0, side_cnt[sd] - 1)];
    return {rand_seg(), rand_seg(), rand_seg(), rand_seg()};
  endfunction

  stim_t directed [] = '{
    '{srsu_pkg::REQ_LOAD_L, {DW{1'b0}}},
    '{srsu_pkg::REQ_LOAD_R, {DW{1'b0}}},
    '{srsu_pkg::REQ_LOAD_L, {DW{1'b1}}},
    '{srsu_pkg::REQ_LOAD_R, {DW{1'b1}}},
    '{srsu_pkg::REQ_LOAD_L, {DW{1'b1}}},
    '{srsu_pkg::REQ_LOAD_L, {64'd7, 64'd2, 64'd1, 64'd5}},
    '{srsu_pkg::REQ_LOAD_R, {64'd9, 64'd2, 64'd1, 64'd5}},
    '{srsu_pkg::REQ_LOAD_R, {64'd0, 64'd2, 64'd1, 64'd5}},
    '{srsu_pkg::REQ_LOAD_L, {ONES, 64'h1_0000_0000, 64'h0000_0001_ffff_ffff, 64'd1}},
    '{srsu_pkg::REQ_LOAD_R, {64'd0, 64'h1_0000_0000, 64'h0000_0001_ffff_ffff, 64'd1}},
    '{REQ_NONE, {DW{1'b1}}},
    '{srsu_pkg::REQ_LOAD_R, {64'd3, 64'd3, 64'd0, ONES}},
    '{srsu_pkg::REQ_LOAD_R, {64'd3, 64'd3, 64'd0, 64'd0}},
    '{REQ_NONE, {DW{1'b0}}}
  };

  // result side: random stalls, some long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 10) begin
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    union_row_t got;
    union_row_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = pending_rows.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: segs exp %h got %h, valid %b/%b chunk_end %b/%b last %b/%b",
                     want.segs, got.segs, want.row_valid, got.row_valid,
                     want.chunk_end, got.chunk_end, want.last_row, got.last_row);
        end
      end
    end
  end

  initial begin
    int n;
    int r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(srsu_pkg::CFG_NUM_SEGMENTS, seg_plan[0]);
    write_reg(srsu_pkg::CFG_CHUNK_ROWS, chunk_plan[0]);
    foreach (directed[k]) send_item(directed[k].req, directed[k].data);
    for (int k = 0; k < 400; k++) begin
      if (k % 50 == 0) quiet = $urandom_range(0, 3) == 0;
      r = $urandom_range(0, 99);
      send_item(r < 3 ? REQ_NONE : (r < 51 ? srsu_pkg::REQ_LOAD_L : srsu_pkg::REQ_LOAD_R),
                rand_row());
    end
    // first pull sorts, later ones merge; loads are ignored from here on
    n = 1;
    for (int k = 0; k < 520; k++) begin
      if (k % 40 == 0) quiet = $urandom_range(0, 3) == 0;
      if (k != 0 && k % 90 == 0 && n < 6) begin
        drain();
        write_reg(srsu_pkg::CFG_NUM_SEGMENTS, seg_plan[n]);
        write_reg(srsu_pkg::CFG_CHUNK_ROWS, chunk_plan[n]);
        n++;
      end
      r = $urandom_range(0, 99);
      if (r < 86) send_item(srsu_pkg::REQ_PULL, rand_row());
      else if (r < 95)
        send_item(r[0] ? srsu_pkg::REQ_LOAD_L : srsu_pkg::REQ_LOAD_R, rand_row());
      else send_item(REQ_NONE, rand_row());
    end
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (pending_rows.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

### sorted_row_set_union.f
hw/rtl/srsu_pkg.sv
hw/rtl/srsu_ctrl.sv
hw/rtl/srsu_dp.sv
hw/rtl/sorted_row_set_union.sv
sim/testbench.sv
